>>> hw/rtl/iwgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgd_pkg
// Shared widths, bounds and types of the int4 weight group dot block.
// ----------------------------------------------------------------------------
package iwgd_pkg;

  localparam int WORD_BYTES  = 4;
  localparam int LANES_DEF   = 4;
  localparam int LANES_MAX   = 16;
  localparam int NIB_W       = 4;
  localparam int ACT_W       = 8;
  localparam int ZP_W        = 8;
  localparam int GS_W        = 20;
  localparam int ZG_W        = ZP_W + 1 + GS_W;
  localparam int LANE_SUM_W  = 13;
  localparam int ACC_W       = 24;
  localparam int OUT_W       = 29;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // stage-1 word handed to the accumulator
  typedef struct packed {
    logic take;
    logic last;
  } iwgd_ctrl_t;

endpackage

>>> hw/rtl/iwgd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgd_lane
// One lane: two nibble-by-int8 products of a weight byte, summed and registered.
// ----------------------------------------------------------------------------
module iwgd_lane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [iwgd_pkg::ACT_W-1:0]         wbyte_i,
  input  logic [iwgd_pkg::ACT_W-1:0]         even_i,
  input  logic [iwgd_pkg::ACT_W-1:0]         odd_i,
  output logic [iwgd_pkg::LANE_SUM_W-1:0]    sum_o
);
  import iwgd_pkg::*;

  logic signed [NIB_W:0]        hi, lo;
  logic signed [NIB_W+ACT_W:0]  p_even, p_odd;
  logic [LANE_SUM_W-1:0]        sum_d, sum_q;

  always_comb begin
    hi     = signed'({1'b0, wbyte_i[2*NIB_W-1:NIB_W]});
    lo     = signed'({1'b0, wbyte_i[NIB_W-1:0]});
    p_even = hi * signed'(even_i);
    p_odd  = lo * signed'(odd_i);
    sum_d  = LANE_SUM_W'(signed'(p_even) + signed'(p_odd));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> hw/rtl/iwgd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwgd_merge
// Adds the lane sums into the saturating group accumulator and forms the
// zero-point corrected result in the output register.
// ----------------------------------------------------------------------------
module iwgd_merge #(
  parameter int NUM_LANES = iwgd_pkg::LANES_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  iwgd_pkg::iwgd_ctrl_t                          ctrl_i,
  input  logic [NUM_LANES-1:0][iwgd_pkg::LANE_SUM_W-1:0] lane_sum_i,
  input  logic [iwgd_pkg::ZG_W-1:0]                     zg_i,
  input  logic                                          out_ready_i,
  output logic                                          out_valid_o,
  output logic [iwgd_pkg::OUT_W-1:0]                    out_data_o
);
  import iwgd_pkg::*;

  localparam int SUM_W = LANE_SUM_W + $clog2(NUM_LANES) + 1;
  localparam int WIDE_W = ACC_W + 2;

  logic signed [SUM_W-1:0]  item_sum;
  logic signed [WIDE_W-1:0] acc_wide;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic [OUT_W-1:0]         res_d, res_q;
  logic                     ovld_d, ovld_q;

  always_comb begin
    item_sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      item_sum = item_sum + SUM_W'(signed'(lane_sum_i[i]));
    end
    acc_wide = WIDE_W'(acc_q) + WIDE_W'(item_sum);
    if (acc_wide > WIDE_W'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (acc_wide < WIDE_W'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_wide[ACC_W-1:0];
    end

    acc_d  = acc_q;
    res_d  = res_q;
    ovld_d = ovld_q;
    if (out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (ctrl_i.take) begin
      if (ctrl_i.last) begin
        acc_d  = '0;
        res_d  = OUT_W'(OUT_W'(acc_sat) - OUT_W'(signed'(zg_i)));
        ovld_d = 1'b1;
      end else begin
        acc_d = acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = res_q;

endmodule

>>> hw/rtl/int4_weight_group_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4_weight_group_dot
// W4A8 group dot product: packed int4 weights times int8 activations,
// accumulated per group with zero-point correction at the group end.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* takes one word per cycle while s_axis_tready is
//   high: four weight bytes, four even and four odd activations, zero point
//   and group activation sum in tdata; tlast marks the last word of a weight group.
//   Master stream m_axis_* returns one corrected group sum per group, sent
//   for the word that carried tlast.
//   The last word of a group passes the lane stage, then the accumulate and
//   output register, before m_axis_tvalid rises.
//   Throughput: one word per cycle while s_axis_tready is high, set by the
//   accumulate loop behind the lane product registers.
//   Words that are not last of a group never wait on the output side.
//   Reset clears the group accumulator and the valid flags of both pipeline stages.
//   When the receiver stalls, the result holds in the output register, one
//   more word can sit in the lane stage, and s_axis_tready drops only when
//   a last word would need the busy output register.
// ----------------------------------------------------------------------------
module int4_weight_group_dot #(
  parameter int LANES = iwgd_pkg::LANES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: weight_bytes[31:0], even_acts[63:32], odd_acts[95:64],
  // zero_point[103:96], group_act_sum[123:104], zero pad[127:124]
  input  logic [iwgd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low bit up: corrected_group_sum[28:0], zero pad[31:29]
  output logic [iwgd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import iwgd_pkg::*;

  localparam int NUM_LANES = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;

  logic [4*ACT_W-1:0]                   w_word, e_word, o_word;
  logic [ZP_W-1:0]                      zp;
  logic [GS_W-1:0]                      gs;
  logic [NUM_LANES-1:0][LANE_SUM_W-1:0] lane_sum;
  logic [ZG_W-1:0]                      zg_d, zg_q;
  logic                                 s1_vld_d, s1_vld_q;
  logic                                 s1_last_d, s1_last_q;
  logic                                 s_accept, s1_take, out_free, out_vld;
  logic [OUT_W-1:0]                     out_data;
  iwgd_ctrl_t                           ctrl;

  assign w_word = s_axis_tdata[31:0];
  assign e_word = s_axis_tdata[63:32];
  assign o_word = s_axis_tdata[95:64];
  assign zp     = s_axis_tdata[103:96];
  assign gs     = s_axis_tdata[123:104];

  always_comb begin
    out_free      = !out_vld || m_axis_tready;
    s1_take       = s1_vld_q && (!s1_last_q || out_free);
    s_axis_tready = !s1_vld_q || s1_take;
    s_accept      = s_axis_tvalid && s_axis_tready;
    s1_vld_d      = s_accept ? 1'b1 : (s1_take ? 1'b0 : s1_vld_q);
    s1_last_d     = s_accept ? s_axis_tlast : s1_last_q;
    zg_d          = s_accept ? ZG_W'(signed'({1'b0, zp})) * ZG_W'(signed'(gs)) : zg_q;
    ctrl.take     = s1_take;
    ctrl.last     = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= s1_last_d;
    zg_q      <= zg_d;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    iwgd_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (s_accept),
      .wbyte_i (w_word[g*ACT_W +: ACT_W]),
      .even_i  (e_word[g*ACT_W +: ACT_W]),
      .odd_i   (o_word[g*ACT_W +: ACT_W]),
      .sum_o   (lane_sum[g])
    );
  end

  iwgd_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .lane_sum_i  (lane_sum),
    .zg_i        (zg_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_vld),
    .out_data_o  (out_data)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data};

endmodule
